[sv/fdpc_pkg.sv]
// shared types and constants of the frame deframer with pin command decoding
package fdpc_pkg;

	localparam int NUMBER_WIDTH_DEF = 16;

	// frame header layout
	localparam logic [2:0] HDR_TYPE   = 3'd0;
	localparam logic [2:0] HDR_ID_HI  = 3'd1;
	localparam logic [2:0] HDR_ID_LO  = 3'd2;
	localparam logic [2:0] HDR_LEN_HI = 3'd3;
	localparam logic [2:0] HDR_LEN_LO = 3'd4;

	localparam logic [7:0]  TYPE_RESPONSE = 8'd0;
	localparam logic [7:0]  TYPE_HARDWARE = 8'd20;
	localparam logic [15:0] LOGIN_OK_CODE = 16'd200;
	localparam logic [15:0] MIN_CMD_BYTES = 16'd3;

	localparam logic [7:0] CHAR_V    = 8'h76;
	localparam logic [7:0] CHAR_R    = 8'h72;
	localparam logic [7:0] CHAR_W    = 8'h77;
	localparam logic [7:0] CHAR_NUL  = 8'h00;
	localparam logic [7:0] CHAR_ZERO = 8'h30;

	typedef enum logic [2:0] {
		EV_LOGIN_OK   = 3'd0,
		EV_LOGIN_FAIL = 3'd1,
		EV_READ       = 3'd2,
		EV_WRITE      = 3'd3,
		EV_CLOSE      = 3'd4
	} event_kind_t;

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_PREFIX = 5'b00010,
		PH_PIN    = 5'b00100,
		PH_VALUE  = 5'b01000,
		PH_SKIP   = 5'b10000
	} phase_t;

	typedef enum logic [1:0] {
		CM_NONE  = 2'd0,
		CM_READ  = 2'd1,
		CM_WRITE = 2'd2,
		CM_V     = 2'd3
	} cmd_t;

endpackage

[sv/frame_deframer_pin_command_core.sv]
// top level of the frame deframer with virtual pin command decoding
// Takes one received byte per beat and splits the stream into frames with a
// five-byte header (type, 16-bit id, 16-bit length, high bytes first). A
// response frame (type 0) carries a status in its length field and gives a
// login ok (200) or login failed event. A hardware frame (type 20) whose
// payload opens with "vr",NUL or "vw",NUL carries NUL-terminated decimal pin
// and value numbers; at the last payload byte it gives a read request or a
// write event. Numbers saturate at 2^NUMBER_WIDTH-1 (or at zero for digits
// below '0') and flag it. A frame id of 0 gives a close event, after which
// bytes are dropped until a beat with restart set. Other frames are skipped.
// Timing: every beat is handled combinationally by the header/payload
// parser and its digit unit, so one byte is accepted per clock; an event
// appears on the master side the cycle after the byte that causes it and
// sits in an output register, so the slave side keeps taking bytes while
// the master side is free or is being drained in the same cycle.
module frame_deframer_pin_command_core #(
	parameter int NUMBER_WIDTH = fdpc_pkg::NUMBER_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] rx_byte
	input  logic [0:0]  s_tuser,  // [0] restart
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [15:0] pin_number, [31:16] write_value
	output logic [3:0]  m_tuser   // [2:0] event_kind, [3] number_overflow
);

	localparam int ExtW = (NUMBER_WIDTH > 16) ? NUMBER_WIDTH : 16;

	// parser state
	fdpc_pkg::phase_t        phase_q, phase_n;
	fdpc_pkg::cmd_t          cmd_q, cmd_n;
	logic [2:0]              hdr_cnt_q, hdr_cnt_n;
	logic [7:0]              type_q, type_n;
	logic [15:0]             id_q, id_n;
	logic [15:0]             len_q, len_n;
	logic [15:0]             pay_cnt_q, pay_cnt_n;
	logic [NUMBER_WIDTH-1:0] pin_acc_q, pin_acc_n;
	logic [NUMBER_WIDTH-1:0] val_acc_q, val_acc_n;
	logic                    closed_q, closed_n;
	logic                    ovf_q, ovf_n;

	// output register
	fdpc_pkg::event_kind_t   kind_q;
	logic [15:0]             pin_q;
	logic [15:0]             val_q;
	logic                    out_ovf_q;

	// event built from the current beat
	logic                    ev_valid;
	fdpc_pkg::event_kind_t   ev_kind;
	logic [15:0]             ev_pin;
	logic [15:0]             ev_val;
	logic                    ev_ovf;

	logic                    s_accept;
	logic [7:0]              rx_byte;
	logic                    restart;
	logic [15:0]             len_full;
	logic [15:0]             pay_inc;
	logic [NUMBER_WIDTH-1:0] dig_in;
	logic [NUMBER_WIDTH-1:0] dig_sum;
	logic                    dig_sat;
	logic [ExtW-1:0]         pin_ext;
	logic [ExtW-1:0]         val_ext;

	assign rx_byte  = s_tdata;
	assign restart  = s_tuser[0];
	assign s_tready = !m_tvalid || m_tready;
	assign s_accept = s_tvalid && s_tready;

	// one digit unit, shared by the pin and value numbers
	assign dig_in = (phase_q == fdpc_pkg::PH_VALUE) ? val_acc_q : pin_acc_q;

	fdpc_digit #(
		.NUMBER_WIDTH(NUMBER_WIDTH)
	) u_digit (
		.acc   (dig_in),
		.digit (rx_byte),
		.sum   (dig_sum),
		.sat   (dig_sat)
	);

	assign len_full = {len_q[15:8], rx_byte};
	assign pay_inc  = pay_cnt_q + 16'd1;

	always_comb begin
		phase_n   = phase_q;
		cmd_n     = cmd_q;
		hdr_cnt_n = hdr_cnt_q;
		type_n    = type_q;
		id_n      = id_q;
		len_n     = len_q;
		pay_cnt_n = pay_cnt_q;
		pin_acc_n = pin_acc_q;
		val_acc_n = val_acc_q;
		closed_n  = closed_q;
		ovf_n     = ovf_q;
		ev_valid  = 1'b0;
		ev_kind   = fdpc_pkg::EV_LOGIN_OK;
		ev_pin    = '0;
		ev_val    = '0;
		ev_ovf    = 1'b0;
		pin_ext   = ExtW'(pin_acc_n);
		val_ext   = ExtW'(val_acc_n);

		if (restart) begin
			// new connection: back to the reset state, byte dropped
			phase_n   = fdpc_pkg::PH_HEADER;
			cmd_n     = fdpc_pkg::CM_NONE;
			hdr_cnt_n = '0;
			type_n    = '0;
			id_n      = '0;
			len_n     = '0;
			pay_cnt_n = '0;
			pin_acc_n = '0;
			val_acc_n = '0;
			closed_n  = 1'b0;
			ovf_n     = 1'b0;
		end else if (!closed_q) begin
			if (phase_q == fdpc_pkg::PH_HEADER) begin
				case (hdr_cnt_q)
					fdpc_pkg::HDR_TYPE:   type_n = rx_byte;
					fdpc_pkg::HDR_ID_HI:  id_n   = {rx_byte, 8'h00};
					fdpc_pkg::HDR_ID_LO:  id_n   = {id_q[15:8], rx_byte};
					fdpc_pkg::HDR_LEN_HI: len_n  = {rx_byte, 8'h00};
					default:              len_n  = len_full;
				endcase
				if (hdr_cnt_q == fdpc_pkg::HDR_LEN_LO) begin
					// header complete: decide what the frame is
					hdr_cnt_n = '0;
					pay_cnt_n = '0;
					cmd_n     = fdpc_pkg::CM_NONE;
					pin_acc_n = '0;
					val_acc_n = '0;
					ovf_n     = 1'b0;
					if (id_q == 16'd0) begin
						closed_n = 1'b1;
						ev_valid = 1'b1;
						ev_kind  = fdpc_pkg::EV_CLOSE;
					end else if (type_q == fdpc_pkg::TYPE_RESPONSE) begin
						ev_valid = 1'b1;
						ev_kind  = (len_full == fdpc_pkg::LOGIN_OK_CODE) ?
							fdpc_pkg::EV_LOGIN_OK : fdpc_pkg::EV_LOGIN_FAIL;
					end else if (len_full != 16'd0) begin
						phase_n = (type_q == fdpc_pkg::TYPE_HARDWARE) ?
							fdpc_pkg::PH_PREFIX : fdpc_pkg::PH_SKIP;
					end
				end else begin
					hdr_cnt_n = hdr_cnt_q + 3'd1;
				end
			end else begin
				case (phase_q)
					fdpc_pkg::PH_PREFIX: begin
						if (pay_cnt_q == 16'd0) begin
							cmd_n = (rx_byte == fdpc_pkg::CHAR_V) ?
								fdpc_pkg::CM_V : fdpc_pkg::CM_NONE;
						end else if (pay_cnt_q == 16'd1) begin
							if (cmd_q == fdpc_pkg::CM_V && rx_byte == fdpc_pkg::CHAR_R) begin
								cmd_n = fdpc_pkg::CM_READ;
							end else if (cmd_q == fdpc_pkg::CM_V &&
									rx_byte == fdpc_pkg::CHAR_W) begin
								cmd_n = fdpc_pkg::CM_WRITE;
							end else begin
								cmd_n = fdpc_pkg::CM_NONE;
							end
						end else begin
							// third prefix byte must be the terminator
							if (rx_byte != fdpc_pkg::CHAR_NUL) begin
								cmd_n = fdpc_pkg::CM_NONE;
							end
							phase_n = (cmd_n == fdpc_pkg::CM_NONE) ?
								fdpc_pkg::PH_SKIP : fdpc_pkg::PH_PIN;
						end
					end
					fdpc_pkg::PH_PIN: begin
						if (rx_byte == fdpc_pkg::CHAR_NUL) begin
							phase_n = (cmd_q == fdpc_pkg::CM_WRITE) ?
								fdpc_pkg::PH_VALUE : fdpc_pkg::PH_SKIP;
						end else begin
							pin_acc_n = dig_sum;
							ovf_n     = ovf_q || dig_sat;
						end
					end
					fdpc_pkg::PH_VALUE: begin
						if (rx_byte == fdpc_pkg::CHAR_NUL) begin
							phase_n = fdpc_pkg::PH_SKIP;
						end else begin
							val_acc_n = dig_sum;
							ovf_n     = ovf_q || dig_sat;
						end
					end
					default: ;
				endcase
				pay_cnt_n = pay_inc;
				pin_ext   = ExtW'(pin_acc_n);
				val_ext   = ExtW'(val_acc_n);
				if (pay_inc >= len_q) begin
					// last payload byte of the frame
					phase_n = fdpc_pkg::PH_HEADER;
					if (pay_inc >= fdpc_pkg::MIN_CMD_BYTES) begin
						if (cmd_n == fdpc_pkg::CM_READ) begin
							ev_valid = 1'b1;
							ev_kind  = fdpc_pkg::EV_READ;
							ev_pin   = pin_ext[15:0];
							ev_ovf   = ovf_n;
						end else if (cmd_n == fdpc_pkg::CM_WRITE) begin
							ev_valid = 1'b1;
							ev_kind  = fdpc_pkg::EV_WRITE;
							ev_pin   = pin_ext[15:0];
							ev_val   = val_ext[15:0];
							ev_ovf   = ovf_n;
						end
					end
				end
			end
		end
	end

	// parser state registers, advanced on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= fdpc_pkg::PH_HEADER;
			cmd_q     <= fdpc_pkg::CM_NONE;
			hdr_cnt_q <= '0;
			type_q    <= '0;
			id_q      <= '0;
			len_q     <= '0;
			pay_cnt_q <= '0;
			pin_acc_q <= '0;
			val_acc_q <= '0;
			closed_q  <= 1'b0;
			ovf_q     <= 1'b0;
		end else if (s_accept) begin
			phase_q   <= phase_n;
			cmd_q     <= cmd_n;
			hdr_cnt_q <= hdr_cnt_n;
			type_q    <= type_n;
			id_q      <= id_n;
			len_q     <= len_n;
			pay_cnt_q <= pay_cnt_n;
			pin_acc_q <= pin_acc_n;
			val_acc_q <= val_acc_n;
			closed_q  <= closed_n;
			ovf_q     <= ovf_n;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (s_accept && ev_valid) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (s_accept && ev_valid) begin
			kind_q    <= ev_kind;
			pin_q     <= ev_pin;
			val_q     <= ev_val;
			out_ovf_q <= ev_ovf;
		end
	end

	assign m_tdata = {val_q, pin_q};
	assign m_tuser = {out_ovf_q, kind_q};

	// header byte counter stays within the header
	a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= fdpc_pkg::HDR_LEN_LO)
		else $error("header byte counter out of range");

	// inside a payload the byte count is below the frame length
	a_pay_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != fdpc_pkg::PH_HEADER |-> pay_cnt_q < len_q)
		else $error("payload count reached frame length inside payload");

	// a closed connection produces no events
	a_closed_silent: assert property (@(posedge clk) disable iff (!arst_n)
		closed_q && !restart |-> !ev_valid)
		else $error("event produced while closed");

	// a close event leaves the parser closed
	a_close_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && ev_valid && ev_kind == fdpc_pkg::EV_CLOSE |=> closed_q)
		else $error("close event did not close the parser");

	// login and close events carry no numbers
	a_plain_event: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (kind_q == fdpc_pkg::EV_LOGIN_OK || kind_q == fdpc_pkg::EV_LOGIN_FAIL ||
			kind_q == fdpc_pkg::EV_CLOSE) |-> m_tdata == 32'd0 && !out_ovf_q)
		else $error("non-command event carries data");

endmodule

[sv/fdpc_digit.sv]
// saturating decimal digit step: acc*10 + byte - '0', clamped to the number range
module fdpc_digit #(
	parameter int NUMBER_WIDTH = fdpc_pkg::NUMBER_WIDTH_DEF
) (
	input  logic [NUMBER_WIDTH-1:0] acc,
	input  logic [7:0]              digit,
	output logic [NUMBER_WIDTH-1:0] sum,
	output logic                    sat
);

	localparam int PW = NUMBER_WIDTH + 4;
	localparam int TW = NUMBER_WIDTH + 5;

	logic [PW-1:0] prod;
	logic [TW-1:0] raw;
	logic [TW-1:0] diff;
	logic          below;
	logic          above;

	always_comb begin
		// times ten as two shifts and an add
		prod  = (PW'(acc) << 3) + (PW'(acc) << 1);
		raw   = {1'b0, prod} + TW'(digit);
		below = raw < TW'(fdpc_pkg::CHAR_ZERO);
		diff  = raw - TW'(fdpc_pkg::CHAR_ZERO);
		above = diff[TW-1:NUMBER_WIDTH] != '0;
		sat   = below || above;
		if (below) begin
			sum = '0;
		end else if (above) begin
			sum = '1;
		end else begin
			sum = diff[NUMBER_WIDTH-1:0];
		end
	end

endmodule
